// ===== hdl/cau_pkg.sv =====
package cau_pkg;

  // operand and result word, fraction bits of the fixed point format
  localparam int OPW        = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PW         = 2 * OPW;
  // phase angle accumulator
  localparam int ANG_FRAC   = 24;
  localparam int ZW         = 34;
  localparam int PRESHIFT   = 30;
  localparam int CORD_ITERS = 28;
  localparam logic [63:0] RAD2DEG_Q24 = 64'd961263669;
  // iteration counts of the shared step chain
  localparam int SQRT_STEPS = OPW;
  localparam int DIV_QBITS  = OPW + 2;
  localparam int NSTEP      = DIV_QBITS;
  // stream widths
  localparam int IN_TDATA_W  = 4 * OPW;
  localparam int OUT_TDATA_W = ((2 * OPW + 1 + 7) / 8) * 8;
  localparam int OUT_PAD     = OUT_TDATA_W - 2 * OPW - 1;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_NEG   = 3'd4,
    OP_EQ    = 3'd5,
    OP_MAG   = 3'd6,
    OP_PHASE = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDEF = 2'd1,
    ST_SAT   = 2'd2
  } status_e;

  typedef struct packed {
    op_e                   op;
    logic signed [OPW-1:0] ar;
    logic signed [OPW-1:0] ai;
    logic signed [OPW-1:0] br;
    logic signed [OPW-1:0] bi;
  } item_t;

  typedef struct packed {
    logic signed [OPW-1:0] re;
    logic signed [OPW-1:0] im;
    logic                  eq;
    status_e               st;
  } res_t;

  typedef struct packed {
    logic                  ovf;
    logic signed [OPW-1:0] val;
  } sat_t;

  // state carried through the iteration chain
  typedef struct packed {
    op_e                   op;
    res_t                  fast;
    logic                  re_neg;
    logic                  im_neg;
    logic [PW-1:0]         re_mag;
    logic [PW-1:0]         im_mag;
    logic [PW-1:0]         den;
    logic                  den_zero;
    logic                  re_ovf;
    logic                  im_ovf;
    logic [PW-1:0]         re_rem;
    logic [PW-1:0]         im_rem;
    logic [DIV_QBITS-1:0]  re_quo;
    logic [DIV_QBITS-1:0]  im_quo;
    logic [PW-1:0]         sq_n;
    logic [PW-1:0]         sq_r;
    logic signed [PW-1:0]  cx;
    logic signed [PW-1:0]  cy;
    logic signed [ZW-1:0]  cz;
    logic                  ph_rz;
    logic                  ph_iz;
    logic                  ph_ineg;
    logic                  ph_flip;
  } iter_t;

  // clamp a sign and magnitude value to the signed word
  function automatic sat_t sat_sm(logic neg, logic [PW-1:0] mag);
    sat_t          s;
    logic [PW-1:0] lim;
    lim   = PW'(1) << (OPW - 1);
    s.ovf = 1'b0;
    if (neg) begin
      if (mag > lim) begin
        s.ovf = 1'b1;
        s.val = {1'b1, {(OPW-1){1'b0}}};
      end else begin
        s.val = OPW'(PW'(0) - mag);
      end
    end else begin
      if (mag > lim - PW'(1)) begin
        s.ovf = 1'b1;
        s.val = {1'b0, {(OPW-1){1'b1}}};
      end else begin
        s.val = OPW'(mag);
      end
    end
    return s;
  endfunction

  // clamp a value one bit wider than the word
  function automatic sat_t sat_s(logic signed [OPW:0] v);
    logic [OPW:0] av;
    av = v[OPW] ? $unsigned(-v) : $unsigned(v);
    return sat_sm(v[OPW], PW'(av));
  endfunction

  // shift and subtract division, for elaboration time constants
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in degrees, Q24, from the arctan series
  function automatic logic [ZW-1:0] atan_deg(int i);
    logic [63:0] acc;
    logic [63:0] term;
    logic [63:0] rad;
    logic [63:0] prod;
    int          k;
    acc = '0;
    if (i == 0) begin
      return ZW'(45) << ANG_FRAC;
    end
    for (k = 0; i * (2 * k + 1) <= 60; k++) begin
      term = udiv64(64'd1 << (60 - i * (2 * k + 1)), 64'(2 * k + 1));
      if (k[0]) acc = acc - term;
      else acc = acc + term;
    end
    rad  = (acc + (64'd1 << 27)) >> 28;
    prod = rad * RAD2DEG_Q24;
    return ZW'((prod + (64'd1 << 31)) >> 32);
  endfunction

endpackage

// ===== hdl/complex_arithmetic_unit_core.sv =====
// the pipeline has 3 operand stages, 34 iteration stages and 1 output register
// (divide steps in each iteration stage, root and phase in the leading ones only)
// throughput: one beat per cycle while the output is not stalled
// a stalled output holds its beat while empty stages upstream keep filling
// reset clears only the valid bits, there is no clearing pass
module complex_arithmetic_unit_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // a_real, a_imag, b_real, b_imag
  input  logic [cau_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // operation
  input  logic [2:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // res_real, res_imag, equal, zero fill
  output logic [cau_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // status
  output logic [1:0]                         m_axis_tuser
);

  localparam int OPW = cau_pkg::OPW;

  cau_pkg::item_t item;
  cau_pkg::iter_t fr_data, it_data;
  cau_pkg::res_t  res;
  logic           fr_valid, fr_ready, it_valid, it_ready;

  // unpack input beat
  assign item.op = cau_pkg::op_e'(s_axis_tuser);
  assign item.ar = $signed(s_axis_tdata[OPW-1:0]);
  assign item.ai = $signed(s_axis_tdata[2*OPW-1:OPW]);
  assign item.br = $signed(s_axis_tdata[3*OPW-1:2*OPW]);
  assign item.bi = $signed(s_axis_tdata[4*OPW-1:3*OPW]);

  cau_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (item),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_data_o  (fr_data)
  );

  cau_iter u_iter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_data_i   (fr_data),
    .out_valid_o (it_valid),
    .out_ready_i (it_ready),
    .out_data_o  (it_data)
  );

  cau_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (it_valid),
    .in_ready_o  (it_ready),
    .in_data_i   (it_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res)
  );

  // pack output beat
  assign m_axis_tdata = {{cau_pkg::OUT_PAD{1'b0}}, res.eq, res.im, res.re};
  assign m_axis_tuser = res.st;

  // an empty output register lets the whole chain advance
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // undefined results are zero
  a_undef_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == cau_pkg::ST_UNDEF) |-> (res.re == '0) && (res.im == '0))
    else $error("undefined result not zero");

  // an equality hit carries no numeric result and no error
  a_equal_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.eq |->
      (res.re == '0) && (res.im == '0) && (m_axis_tuser == cau_pkg::ST_OK))
    else $error("equal flag with stray result");

  // no status code beyond saturation
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == cau_pkg::ST_OK) || (m_axis_tuser == cau_pkg::ST_UNDEF)
      || (m_axis_tuser == cau_pkg::ST_SAT))
    else $error("bad status code");

endmodule

// ===== hdl/cau_front.sv =====
module cau_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cau_pkg::item_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output cau_pkg::iter_t  out_data_o
);

  localparam int PW  = cau_pkg::PW;
  localparam int OPW = cau_pkg::OPW;
  localparam int RSH = cau_pkg::DIV_QBITS - cau_pkg::FRAC_BITS;

  typedef struct packed {
    cau_pkg::op_e          op;
    cau_pkg::res_t         fast;
    logic signed [OPW-1:0] ar;
    logic signed [OPW-1:0] ai;
    logic signed [PW-1:0]  m0;
    logic signed [PW-1:0]  m1;
    logic signed [PW-1:0]  m2;
    logic signed [PW-1:0]  m3;
    logic signed [PW-1:0]  m4;
    logic signed [PW-1:0]  m5;
  } f1_t;

  typedef struct packed {
    cau_pkg::op_e          op;
    cau_pkg::res_t         fast;
    logic signed [PW:0]    s_re;
    logic signed [PW:0]    s_im;
    logic [PW-1:0]         den;
    logic signed [PW-1:0]  cx;
    logic signed [PW-1:0]  cy;
    logic                  ph_rz;
    logic                  ph_iz;
    logic                  ph_ineg;
    logic                  ph_flip;
  } f2_t;

  f1_t            f1_d, f1_q;
  f2_t            f2_d, f2_q;
  cau_pkg::iter_t f3_d, f3_q;
  logic           v1_q, v2_q, v3_q;
  logic           en1, en2, en3;

  logic signed [OPW-1:0] mr, mi;
  cau_pkg::sat_t         sr, si;
  logic [OPW:0]          aar, aai;
  logic [PW:0]           are, aim;

  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  // stage 1: products and the add, subtract, negate and equality operations
  always_comb begin
    mr      = (in_data_i.op == cau_pkg::OP_MAG) ? in_data_i.ar : in_data_i.br;
    mi      = (in_data_i.op == cau_pkg::OP_MAG) ? in_data_i.ai : in_data_i.bi;
    f1_d.op = in_data_i.op;
    f1_d.ar = in_data_i.ar;
    f1_d.ai = in_data_i.ai;
    f1_d.m0 = in_data_i.ar * mr;
    f1_d.m1 = in_data_i.ai * mi;
    f1_d.m2 = in_data_i.ar * in_data_i.bi;
    f1_d.m3 = in_data_i.ai * in_data_i.br;
    f1_d.m4 = in_data_i.br * in_data_i.br;
    f1_d.m5 = in_data_i.bi * in_data_i.bi;
    sr = '0;
    si = '0;
    f1_d.fast.eq = 1'b0;
    unique case (in_data_i.op)
      cau_pkg::OP_ADD: begin
        sr = cau_pkg::sat_s((OPW+1)'(in_data_i.ar) + (OPW+1)'(in_data_i.br));
        si = cau_pkg::sat_s((OPW+1)'(in_data_i.ai) + (OPW+1)'(in_data_i.bi));
      end
      cau_pkg::OP_SUB: begin
        sr = cau_pkg::sat_s((OPW+1)'(in_data_i.ar) - (OPW+1)'(in_data_i.br));
        si = cau_pkg::sat_s((OPW+1)'(in_data_i.ai) - (OPW+1)'(in_data_i.bi));
      end
      cau_pkg::OP_NEG: begin
        sr = cau_pkg::sat_s(-(OPW+1)'(in_data_i.ar));
        si = cau_pkg::sat_s(-(OPW+1)'(in_data_i.ai));
      end
      cau_pkg::OP_EQ: begin
        f1_d.fast.eq = (in_data_i.ar == in_data_i.br) && (in_data_i.ai == in_data_i.bi);
      end
      default: begin
      end
    endcase
    f1_d.fast.re = sr.val;
    f1_d.fast.im = si.val;
    f1_d.fast.st = (sr.ovf || si.ovf) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
  end

  // stage 2: sums of products, divisor, vectoring start point
  always_comb begin
    f2_d.op   = f1_q.op;
    f2_d.fast = f1_q.fast;
    if (f1_q.op == cau_pkg::OP_MUL) begin
      f2_d.s_re = (PW+1)'(f1_q.m0) - (PW+1)'(f1_q.m1);
      f2_d.s_im = (PW+1)'(f1_q.m2) + (PW+1)'(f1_q.m3);
    end else begin
      f2_d.s_re = (PW+1)'(f1_q.m0) + (PW+1)'(f1_q.m1);
      f2_d.s_im = (PW+1)'(f1_q.m3) - (PW+1)'(f1_q.m2);
    end
    f2_d.den = $unsigned(f1_q.m4) + $unsigned(f1_q.m5);
    aar = f1_q.ar[OPW-1] ? $unsigned(-(OPW+1)'(f1_q.ar)) : $unsigned((OPW+1)'(f1_q.ar));
    aai = f1_q.ai[OPW-1] ? $unsigned(-(OPW+1)'(f1_q.ai)) : $unsigned((OPW+1)'(f1_q.ai));
    f2_d.cx      = $signed(PW'(aar) << cau_pkg::PRESHIFT);
    f2_d.cy      = $signed(PW'(aai) << cau_pkg::PRESHIFT);
    f2_d.ph_rz   = (f1_q.ar == '0);
    f2_d.ph_iz   = (f1_q.ai == '0);
    f2_d.ph_ineg = f1_q.ai[OPW-1];
    f2_d.ph_flip = f1_q.ar[OPW-1] ^ f1_q.ai[OPW-1];
  end

  // stage 3: sign and magnitude, divider and root start state
  always_comb begin
    are = f2_q.s_re[PW] ? $unsigned(-f2_q.s_re) : $unsigned(f2_q.s_re);
    aim = f2_q.s_im[PW] ? $unsigned(-f2_q.s_im) : $unsigned(f2_q.s_im);
    f3_d.op       = f2_q.op;
    f3_d.fast     = f2_q.fast;
    f3_d.re_neg   = f2_q.s_re[PW];
    f3_d.im_neg   = f2_q.s_im[PW];
    f3_d.re_mag   = are[PW-1:0];
    f3_d.im_mag   = aim[PW-1:0];
    f3_d.den      = f2_q.den;
    f3_d.den_zero = (f2_q.den == '0);
    f3_d.re_rem   = are[PW-1:0] >> RSH;
    f3_d.im_rem   = aim[PW-1:0] >> RSH;
    f3_d.re_ovf   = (are[PW-1:0] >> RSH) >= f2_q.den;
    f3_d.im_ovf   = (aim[PW-1:0] >> RSH) >= f2_q.den;
    f3_d.re_quo   = '0;
    f3_d.im_quo   = '0;
    f3_d.sq_n     = are[PW-1:0];
    f3_d.sq_r     = '0;
    f3_d.cx       = f2_q.cx;
    f3_d.cy       = f2_q.cy;
    f3_d.cz       = '0;
    f3_d.ph_rz    = f2_q.ph_rz;
    f3_d.ph_iz    = f2_q.ph_iz;
    f3_d.ph_ineg  = f2_q.ph_ineg;
    f3_d.ph_flip  = f2_q.ph_flip;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en1) f1_q <= f1_d;
    if (en2) f2_q <= f2_d;
    if (en3) f3_q <= f3_d;
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = f3_q;

endmodule

// ===== hdl/cau_iter.sv =====
module cau_iter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cau_pkg::iter_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output cau_pkg::iter_t  out_data_o
);

  localparam int PW    = cau_pkg::PW;
  localparam int NSTEP = cau_pkg::NSTEP;
  localparam int QW    = cau_pkg::DIV_QBITS;
  localparam int FB    = cau_pkg::FRAC_BITS;

  cau_pkg::iter_t   st_q [NSTEP];
  logic [NSTEP-1:0] v_q;
  logic [NSTEP-1:0] en;

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    localparam int QB  = QW - 1 - k;
    localparam int SQS = (k < cau_pkg::SQRT_STEPS) ? PW - 2 - 2 * k : 0;
    localparam logic [PW-1:0] SQB = PW'(1) << SQS;
    localparam logic signed [cau_pkg::ZW-1:0] ANG = $signed(cau_pkg::atan_deg(k));

    cau_pkg::iter_t       cur, nxt;
    logic                 v_in;
    logic                 en_out;
    logic [PW+FB-1:0]     nre, nim;
    logic [PW:0]          r2re, r2im;
    logic                 gere, geim;
    logic [PW-1:0]        sqt;
    logic signed [PW-1:0] dx, dy;

    if (k == 0) begin : g_first
      assign cur  = in_data_i;
      assign v_in = in_valid_i;
    end else begin : g_next
      assign cur  = st_q[k-1];
      assign v_in = v_q[k-1];
    end

    if (k == NSTEP - 1) begin : g_last
      assign en_out = out_ready_i;
    end else begin : g_mid
      assign en_out = en[k+1];
    end

    assign en[k] = !v_q[k] || en_out;

    // one quotient bit per part; root bit, rotation in early steps
    always_comb begin
      nxt = cur;
      sqt = '0;
      dx  = '0;
      dy  = '0;
      nre = {cur.re_mag, {FB{1'b0}}};
      nim = {cur.im_mag, {FB{1'b0}}};
      r2re = {cur.re_rem, nre[QB]};
      r2im = {cur.im_rem, nim[QB]};
      gere = r2re >= {1'b0, cur.den};
      geim = r2im >= {1'b0, cur.den};
      nxt.re_rem = gere ? PW'(r2re - {1'b0, cur.den}) : PW'(r2re);
      nxt.im_rem = geim ? PW'(r2im - {1'b0, cur.den}) : PW'(r2im);
      nxt.re_quo = {cur.re_quo[QW-2:0], gere};
      nxt.im_quo = {cur.im_quo[QW-2:0], geim};
      if (k < cau_pkg::SQRT_STEPS) begin
        sqt = cur.sq_r + SQB;
        if (cur.sq_n >= sqt) begin
          nxt.sq_n = cur.sq_n - sqt;
          nxt.sq_r = (cur.sq_r >> 1) + SQB;
        end else begin
          nxt.sq_r = cur.sq_r >> 1;
        end
      end
      if (k < cau_pkg::CORD_ITERS) begin
        dx = cur.cx >>> k;
        dy = cur.cy[PW-1] ? -((-cur.cy) >>> k) : (cur.cy >>> k);
        if (!cur.cy[PW-1]) begin
          nxt.cx = cur.cx + dy;
          nxt.cy = cur.cy - dx;
          nxt.cz = cur.cz + ANG;
        end else begin
          nxt.cx = cur.cx - dy;
          nxt.cy = cur.cy + dx;
          nxt.cz = cur.cz - ANG;
        end
      end
    end

    // valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_in;
      end
    end

    // step payload
    always_ff @(posedge clk_i) begin
      if (en[k]) st_q[k] <= nxt;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NSTEP-1];
  assign out_data_o  = st_q[NSTEP-1];

endmodule

// ===== hdl/cau_back.sv =====
module cau_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cau_pkg::iter_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output cau_pkg::res_t   out_data_o
);

  localparam int PW  = cau_pkg::PW;
  localparam int QW  = cau_pkg::DIV_QBITS;
  localparam int ZW  = cau_pkg::ZW;
  localparam int ASH = cau_pkg::ANG_FRAC - cau_pkg::FRAC_BITS;
  localparam logic [PW-1:0] HALF    = PW'(1) << (cau_pkg::FRAC_BITS - 1);
  localparam logic [PW-1:0] AHALF   = PW'(1) << (ASH - 1);
  localparam logic [PW-1:0] NINETY  = PW'(90) << cau_pkg::FRAC_BITS;

  cau_pkg::res_t res_d, res_q;
  logic          v_q;
  logic          en;
  cau_pkg::sat_t sr, si;
  logic [QW:0]   qre, qim;
  logic [PW-1:0] sqr;
  logic [ZW-1:0] zabs;
  logic [PW-1:0] zmag;
  logic          zneg;

  assign en         = !v_q || out_ready_i;
  assign in_ready_o = en;

  // rounding, saturation and result select
  always_comb begin
    qre = (QW+1)'(in_data_i.re_quo)
        + (QW+1)'({in_data_i.re_rem, 1'b0} >= {1'b0, in_data_i.den});
    qim = (QW+1)'(in_data_i.im_quo)
        + (QW+1)'({in_data_i.im_rem, 1'b0} >= {1'b0, in_data_i.den});
    sqr  = in_data_i.sq_r + PW'(in_data_i.sq_n > in_data_i.sq_r);
    zabs = in_data_i.cz[ZW-1] ? $unsigned(-in_data_i.cz) : $unsigned(in_data_i.cz);
    zmag = (PW'(zabs) + AHALF) >> ASH;
    zneg = in_data_i.cz[ZW-1] ^ in_data_i.ph_flip;
    sr = '0;
    si = '0;
    res_d = '0;
    unique case (in_data_i.op) inside
      cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_NEG, cau_pkg::OP_EQ: begin
        res_d = in_data_i.fast;
      end
      cau_pkg::OP_MUL: begin
        sr = cau_pkg::sat_sm(in_data_i.re_neg, (in_data_i.re_mag + HALF) >> cau_pkg::FRAC_BITS);
        si = cau_pkg::sat_sm(in_data_i.im_neg, (in_data_i.im_mag + HALF) >> cau_pkg::FRAC_BITS);
        res_d.re = sr.val;
        res_d.im = si.val;
        res_d.st = (sr.ovf || si.ovf) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
      cau_pkg::OP_DIV: begin
        if (in_data_i.den_zero) begin
          res_d.st = cau_pkg::ST_UNDEF;
        end else begin
          sr = cau_pkg::sat_sm(in_data_i.re_neg, in_data_i.re_ovf ? '1 : PW'(qre));
          si = cau_pkg::sat_sm(in_data_i.im_neg, in_data_i.im_ovf ? '1 : PW'(qim));
          res_d.re = sr.val;
          res_d.im = si.val;
          res_d.st = (sr.ovf || si.ovf) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
      end
      cau_pkg::OP_MAG: begin
        sr = cau_pkg::sat_sm(1'b0, sqr);
        res_d.re = sr.val;
        res_d.st = sr.ovf ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
      cau_pkg::OP_PHASE: begin
        if (in_data_i.ph_rz) begin
          if (in_data_i.ph_iz) begin
            res_d.st = cau_pkg::ST_UNDEF;
          end else begin
            sr = cau_pkg::sat_sm(in_data_i.ph_ineg, NINETY);
            res_d.re = sr.val;
            res_d.st = sr.ovf ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
          end
        end else begin
          sr = cau_pkg::sat_sm(zneg && (zmag != '0), zmag);
          res_d.re = sr.val;
          res_d.st = sr.ovf ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= in_valid_i;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (en) res_q <= res_d;
  end

  assign out_valid_o = v_q;
  assign out_data_o  = res_q;

endmodule
